// File: rtl/smcl_pkg.sv
// shared types and constants for the slice minimum centroid locator
// no dependencies; compiled first
`timescale 1ns / 1ps
`default_nettype none

package smcl_pkg;

  // index ranges that count as inside the volume
  localparam int MAX_COLS   = 512;
  localparam int MAX_ROWS   = 512;
  localparam int MAX_SLICES = 1024;

  // field widths
  localparam int VAL_W      = 32;
  localparam int COL_W      = 9;
  localparam int ROW_W      = 9;
  localparam int SLC_W      = 10;
  localparam int NUM_W      = 10;
  localparam int POS_W      = 32;
  localparam int SUM_W      = 28;
  localparam int CNT_W      = 19;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // saturation limits of the running sums and tie count
  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // point queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_CEILING = 3'd0,
    REG_SPACING_COL   = 3'd1,
    REG_SPACING_ROW   = 3'd2,
    REG_SPACING_SLICE = 3'd3,
    REG_ORIGIN_COL    = 3'd4,
    REG_ORIGIN_ROW    = 3'd5,
    REG_ORIGIN_SLICE  = 3'd6
  } cfg_reg_t;

  // configuration register set
  typedef struct packed {
    logic signed [VAL_W-1:0] start_ceiling;
    logic [VAL_W-1:0]        spacing_col;
    logic [VAL_W-1:0]        spacing_row;
    logic [VAL_W-1:0]        spacing_slice;
    logic signed [VAL_W-1:0] origin_col;
    logic signed [VAL_W-1:0] origin_row;
    logic signed [VAL_W-1:0] origin_slice;
  } cfg_t;

  // one finished slice waiting for division and scaling
  typedef struct packed {
    logic [NUM_W-1:0] point_number;
    logic [SUM_W-1:0] sum_col;
    logic [SUM_W-1:0] sum_row;
    logic [CNT_W-1:0] tie_count;
    logic [SLC_W-1:0] slice;
  } job_t;

endpackage

`default_nettype wire

// File: rtl/smcl_if.sv
// valid/ready channel interfaces for voxels in and points out
// uses smcl_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface smcl_vox_if;
  logic                                valid;
  logic                                ready;
  logic signed [smcl_pkg::VAL_W-1:0]   level_value;
  logic [smcl_pkg::COL_W-1:0]          col;
  logic [smcl_pkg::ROW_W-1:0]          row;
  logic [smcl_pkg::SLC_W-1:0]          slice;
  logic                                last_in_slice;

  modport source (output valid, level_value, col, row, slice, last_in_slice, input ready);
  modport sink   (input valid, level_value, col, row, slice, last_in_slice, output ready);
endinterface

interface smcl_pt_if;
  logic                                valid;
  logic                                ready;
  logic [smcl_pkg::NUM_W-1:0]          point_number;
  logic signed [smcl_pkg::POS_W-1:0]   pos_col;
  logic signed [smcl_pkg::POS_W-1:0]   pos_row;
  logic signed [smcl_pkg::POS_W-1:0]   pos_slice;

  modport source (output valid, point_number, pos_col, pos_row, pos_slice, input ready);
  modport sink   (input valid, point_number, pos_col, pos_row, pos_slice, output ready);
endinterface

`default_nettype wire

// File: rtl/smcl_front.sv
// front end: takes voxels, tracks the per-slice minimum and its index sums
// depends on smcl_pkg and smcl_if; pushes finished slices as jobs
`timescale 1ns / 1ps
`default_nettype none

module smcl_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire smcl_pkg::cfg_t cfg,
  smcl_vox_if.sink            in_vox,
  input  wire logic           q_full,
  output smcl_pkg::job_t      push_job,
  output logic                push
);
  import smcl_pkg::*;

  logic signed [VAL_W-1:0] slice_min_r, slice_min_nxt;
  logic                    min_found_r, min_found_nxt;
  logic [SUM_W-1:0]        sum_col_r, sum_col_nxt;
  logic [SUM_W-1:0]        sum_row_r, sum_row_nxt;
  logic [CNT_W-1:0]        tie_count_r, tie_count_nxt;
  logic [NUM_W-1:0]        points_r, points_nxt;

  logic                    xfer;
  logic                    in_range;
  logic signed [VAL_W-1:0] bound;
  logic                    qualifies;
  logic                    new_min;
  logic                    add_tie;
  logic [SUM_W:0]          col_add;
  logic [SUM_W:0]          row_add;
  logic                    emit;

  assign in_vox.ready = !q_full;
  assign xfer         = in_vox.valid && in_vox.ready;

  // qualification against ceiling or current minimum
  always_comb begin
    in_range  = (int'(in_vox.col) < MAX_COLS) && (int'(in_vox.row) < MAX_ROWS) &&
                (int'(in_vox.slice) < MAX_SLICES);
    bound     = min_found_r ? slice_min_r : cfg.start_ceiling;
    qualifies = in_range && (in_vox.level_value <= bound);
    new_min   = qualifies && (!min_found_r || (in_vox.level_value < slice_min_r));
    add_tie   = qualifies && !new_min && (tie_count_r < CNT_MAX);
    col_add   = {1'b0, sum_col_r} + (SUM_W+1)'(in_vox.col);
    row_add   = {1'b0, sum_row_r} + (SUM_W+1)'(in_vox.row);
  end

  // slice state update
  always_comb begin
    slice_min_nxt = slice_min_r;
    min_found_nxt = min_found_r;
    sum_col_nxt   = sum_col_r;
    sum_row_nxt   = sum_row_r;
    tie_count_nxt = tie_count_r;
    points_nxt    = points_r;
    emit          = 1'b0;
    if (xfer) begin
      priority if (new_min) begin
        slice_min_nxt = in_vox.level_value;
        min_found_nxt = 1'b1;
        sum_col_nxt   = SUM_W'(in_vox.col);
        sum_row_nxt   = SUM_W'(in_vox.row);
        tie_count_nxt = CNT_W'(1);
      end else if (add_tie) begin
        sum_col_nxt   = (col_add > {1'b0, SUM_MAX}) ? SUM_MAX : col_add[SUM_W-1:0];
        sum_row_nxt   = (row_add > {1'b0, SUM_MAX}) ? SUM_MAX : row_add[SUM_W-1:0];
        tie_count_nxt = tie_count_r + CNT_W'(1);
      end else begin
        tie_count_nxt = tie_count_r;
      end
      if (in_vox.last_in_slice) begin
        emit = min_found_nxt && (slice_min_nxt <= 0) && (tie_count_nxt != '0);
        if (emit) begin
          points_nxt = points_r + NUM_W'(1);
        end
      end
    end
  end

  // job handed to the queue at slice end
  always_comb begin
    push                  = emit;
    push_job.point_number = points_r;
    push_job.sum_col      = sum_col_nxt;
    push_job.sum_row      = sum_row_nxt;
    push_job.tie_count    = tie_count_nxt;
    push_job.slice        = in_vox.slice;
  end

  // control state; slice end clears the minimum tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_found_r <= 1'b0;
      tie_count_r <= '0;
      sum_col_r   <= '0;
      sum_row_r   <= '0;
      points_r    <= '0;
    end else if (xfer && in_vox.last_in_slice) begin
      min_found_r <= 1'b0;
      tie_count_r <= '0;
      sum_col_r   <= '0;
      sum_row_r   <= '0;
      points_r    <= points_nxt;
    end else begin
      min_found_r <= min_found_nxt;
      tie_count_r <= tie_count_nxt;
      sum_col_r   <= sum_col_nxt;
      sum_row_r   <= sum_row_nxt;
      points_r    <= points_nxt;
    end
  end

  // minimum value is only read while a minimum is marked found
  always_ff @(posedge clk) begin
    slice_min_r <= slice_min_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/smcl_queue.sv
// short job queue that decouples the front end from the back end
// depends on smcl_pkg
`timescale 1ns / 1ps
`default_nettype none

module smcl_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire smcl_pkg::job_t push_job,
  input  wire logic           pop,
  output smcl_pkg::job_t      head_job,
  output logic                not_empty,
  output logic                full
);
  import smcl_pkg::*;

  job_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   fill_r;
  logic              do_push;
  logic              do_pop;

  assign full      = (fill_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (fill_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_job  = slot_r[rd_ptr_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   fill_r <= fill_r + (QPTR_W+1)'(1);
        2'b01:   fill_r <= fill_r - (QPTR_W+1)'(1);
        default: fill_r <= fill_r;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

// File: rtl/smcl_back.sv
// back end: divides the index sums, scales by spacing, adds origin, saturates
// depends on smcl_pkg and smcl_if; drives the point output register
`timescale 1ns / 1ps
`default_nettype none

module smcl_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire smcl_pkg::cfg_t cfg,
  input  wire smcl_pkg::job_t head_job,
  input  wire logic           job_valid,
  output logic                pop,
  smcl_pt_if.source           out_pt
);
  import smcl_pkg::*;

  localparam int              PROD_W   = SUM_W + VAL_W;
  localparam int              ACC_W    = PROD_W + 2;
  localparam logic [4:0]      DIV_LAST = 5'(SUM_W - 1);

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_MUL, S_ADD, S_OUT} state_t;
  typedef enum logic [1:0] {AX_COL, AX_ROW, AX_SLC} axis_t;

  state_t                  state_r;
  axis_t                   axis_r;
  logic [4:0]              div_cnt_r;
  logic [SUM_W-1:0]        dq_col_r;
  logic [SUM_W-1:0]        dq_row_r;
  logic [CNT_W-1:0]        rem_col_r;
  logic [CNT_W-1:0]        rem_row_r;
  logic [CNT_W-1:0]        divisor_r;
  logic [SLC_W-1:0]        slice_r;
  logic [PROD_W-1:0]       prod_r;
  logic                    valid_r;
  logic [NUM_W-1:0]        num_r;
  logic signed [POS_W-1:0] pos_col_r;
  logic signed [POS_W-1:0] pos_row_r;
  logic signed [POS_W-1:0] pos_slice_r;

  logic [CNT_W:0]          rsh_col;
  logic [CNT_W:0]          rsh_row;
  logic                    ge_col;
  logic                    ge_row;
  logic [SUM_W-1:0]        mul_idx;
  logic [VAL_W-1:0]        mul_sp;
  logic signed [VAL_W-1:0] add_org;
  logic signed [ACC_W-1:0] acc;
  logic signed [POS_W-1:0] sat;

  assign pop = (state_r == S_IDLE) && job_valid;

  // one restoring division step for both axes
  always_comb begin
    rsh_col = {rem_col_r, dq_col_r[SUM_W-1]};
    rsh_row = {rem_row_r, dq_row_r[SUM_W-1]};
    ge_col  = rsh_col >= {1'b0, divisor_r};
    ge_row  = rsh_row >= {1'b0, divisor_r};
  end

  // operand selection for the shared multiplier
  always_comb begin
    unique case (axis_r)
      AX_COL: begin
        mul_idx = dq_col_r;
        mul_sp  = cfg.spacing_col;
        add_org = cfg.origin_col;
      end
      AX_ROW: begin
        mul_idx = dq_row_r;
        mul_sp  = cfg.spacing_row;
        add_org = cfg.origin_row;
      end
      default: begin
        mul_idx = SUM_W'(slice_r);
        mul_sp  = cfg.spacing_slice;
        add_org = cfg.origin_slice;
      end
    endcase
  end

  // offset and saturate to signed 32 bits
  always_comb begin
    acc = $signed({2'b00, prod_r}) + ACC_W'(add_org);
    if (acc[ACC_W-1:POS_W-1] == '0 || acc[ACC_W-1:POS_W-1] == '1) begin
      sat = acc[POS_W-1:0];
    end else if (acc[ACC_W-1]) begin
      sat = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(POS_W-1){1'b1}}};
    end
  end

  // sequencer, datapath and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      valid_r   <= 1'b0;
      axis_r    <= AX_COL;
      div_cnt_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            dq_col_r  <= head_job.sum_col;
            dq_row_r  <= head_job.sum_row;
            rem_col_r <= '0;
            rem_row_r <= '0;
            divisor_r <= head_job.tie_count;
            slice_r   <= head_job.slice;
            num_r     <= head_job.point_number;
            div_cnt_r <= '0;
            axis_r    <= AX_COL;
            state_r   <= S_DIV;
          end
        end
        S_DIV: begin
          rem_col_r <= ge_col ? CNT_W'(rsh_col - {1'b0, divisor_r}) : rsh_col[CNT_W-1:0];
          rem_row_r <= ge_row ? CNT_W'(rsh_row - {1'b0, divisor_r}) : rsh_row[CNT_W-1:0];
          dq_col_r  <= {dq_col_r[SUM_W-2:0], ge_col};
          dq_row_r  <= {dq_row_r[SUM_W-2:0], ge_row};
          div_cnt_r <= div_cnt_r + 5'd1;
          if (div_cnt_r == DIV_LAST) begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= PROD_W'(mul_idx) * PROD_W'(mul_sp);
          state_r <= S_ADD;
        end
        S_ADD: begin
          unique case (axis_r)
            AX_COL: begin
              pos_col_r <= sat;
              axis_r    <= AX_ROW;
              state_r   <= S_MUL;
            end
            AX_ROW: begin
              pos_row_r <= sat;
              axis_r    <= AX_SLC;
              state_r   <= S_MUL;
            end
            default: begin
              pos_slice_r <= sat;
              valid_r     <= 1'b1;
              state_r     <= S_OUT;
            end
          endcase
        end
        S_OUT: begin
          if (out_pt.ready) begin
            valid_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_pt.valid        = valid_r;
  assign out_pt.point_number = num_r;
  assign out_pt.pos_col      = pos_col_r;
  assign out_pt.pos_row      = pos_row_r;
  assign out_pt.pos_slice    = pos_slice_r;

endmodule

`default_nettype wire

// File: rtl/slice_minimum_centroid_locator_unit.sv
// Slice minimum centroid locator. Voxels arrive on in_vox in raster order, one
// slice after another; the front end takes one voxel per clock and tracks the
// per-slice minimum (not above start_ceiling) with the column and row sums and
// count of the voxels that tie it. At the voxel marked last_in_slice a slice
// whose minimum is at or below zero becomes a point job in a four-deep queue.
// The back end handles one point at a time: a bit-serial divider that forms
// both mean indices at once, then three passes of one 28x32 multiplier plus
// an offset-and-saturate step, then the point waits in the output register
// until out_pt takes it. Input is stalled only when four points are queued.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while the block is idle, and the block itself does not
// enforce this. Indexes beyond the register list are ignored.
// depends on smcl_pkg, smcl_if, smcl_front, smcl_queue, smcl_back
`timescale 1ns / 1ps
`default_nettype none

module slice_minimum_centroid_locator_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  smcl_vox_if.sink                               in_vox,
  smcl_pt_if.source                              out_pt,
  input  wire logic                              cfg_we,
  input  wire logic [smcl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [smcl_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import smcl_pkg::*;

  cfg_t cfg_r;
  job_t push_job;
  job_t head_job;
  logic push;
  logic pop;
  logic q_full;
  logic q_not_empty;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_ceiling <= '0;
      cfg_r.spacing_col   <= VAL_W'(65536);
      cfg_r.spacing_row   <= VAL_W'(65536);
      cfg_r.spacing_slice <= VAL_W'(65536);
      cfg_r.origin_col    <= '0;
      cfg_r.origin_row    <= '0;
      cfg_r.origin_slice  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_CEILING: cfg_r.start_ceiling <= cfg_data;
        REG_SPACING_COL:   cfg_r.spacing_col   <= cfg_data;
        REG_SPACING_ROW:   cfg_r.spacing_row   <= cfg_data;
        REG_SPACING_SLICE: cfg_r.spacing_slice <= cfg_data;
        REG_ORIGIN_COL:    cfg_r.origin_col    <= cfg_data;
        REG_ORIGIN_ROW:    cfg_r.origin_row    <= cfg_data;
        REG_ORIGIN_SLICE:  cfg_r.origin_slice  <= cfg_data;
        default:           cfg_r               <= cfg_r;
      endcase
    end
  end

  // voxel intake and minimum tracking
  smcl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_vox   (in_vox),
    .q_full   (q_full),
    .push_job (push_job),
    .push     (push)
  );

  // point job queue
  smcl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .head_job  (head_job),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  // mean, scaling and output
  smcl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head_job  (head_job),
    .job_valid (q_not_empty),
    .pop       (pop),
    .out_pt    (out_pt)
  );

endmodule

`default_nettype wire

// File: rtl/smcl_chk.sv
// port-level checks for the slice minimum centroid locator
// depends on smcl_pkg; bound to the top level at the end of this file
`timescale 1ns / 1ps
`default_nettype none

module smcl_chk (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [smcl_pkg::NUM_W-1:0]    out_point_number,
  input wire logic [smcl_pkg::POS_W-1:0]    out_pos_col
);
  import smcl_pkg::*;

  logic [NUM_W-1:0] expect_num_r;

  // expected point number, one more per point transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_num_r <= '0;
    end else if (out_valid && out_ready) begin
      expect_num_r <= expect_num_r + NUM_W'(1);
    end
  end

  // a waiting point holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_point_number) && $stable(out_pos_col))
    else $error("point changed while stalled");

  // reset leaves no point pending
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("point valid right after reset");

  // points are numbered consecutively from zero
  a_numbering: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_point_number == expect_num_r)
    else $error("point number out of sequence");

endmodule

bind slice_minimum_centroid_locator_unit smcl_chk u_smcl_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_pt.valid),
  .out_ready        (out_pt.ready),
  .out_point_number (out_pt.point_number),
  .out_pos_col      (out_pt.pos_col)
);

`default_nettype wire
